FILE: rtl/rtmp_chunk_stream_deframer_defines.svh
// Assertion macros for the chunk stream deframer.
`ifndef RTMP_CHUNK_STREAM_DEFRAMER_DEFINES_SVH
`define RTMP_CHUNK_STREAM_DEFRAMER_DEFINES_SVH
// Check a property at every clock edge outside reset.
`define RCSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition implies another in the next cycle.
`define RCSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`endif

FILE: rtl/rcsd_pkg.sv
// Package of the chunk stream deframer: codes, record type and header table.
`timescale 1ns / 1ps
package rcsd_pkg;

  localparam int unsigned NumChannels = 64;
  localparam int unsigned ChanW = $clog2(NumChannels);
  localparam logic [23:0] ChunkSizeReset = 24'd128;
  localparam logic [23:0] ExtMarker = 24'hffffff;

  localparam logic [3:0] PhBasic   = 4'd0;
  localparam logic [3:0] PhId1     = 4'd1;
  localparam logic [3:0] PhId2a    = 4'd2;
  localparam logic [3:0] PhId2b    = 4'd3;
  localparam logic [3:0] PhLoad    = 4'd4;
  localparam logic [3:0] PhMsgHdr  = 4'd5;
  localparam logic [3:0] PhExt     = 4'd6;
  localparam logic [3:0] PhPayload = 4'd7;
  localparam logic [3:0] PhError   = 4'd8;

  typedef enum logic [1:0] {
    KindPayload = 2'd0,
    KindEmpty   = 2'd1,
    KindBadChan = 2'd2
  } kind_e;

  typedef struct packed {
    logic [31:0] delta;
    logic [31:0] ts;
    logic [23:0] len;
    logic [7:0]  typ;
    logic [31:0] stream;
    logic [23:0] rem;
    logic        inprog;
    logic        ext;
  } chan_rec_t;

  typedef struct packed {
    kind_e       kind;
    logic [5:0]  channel;
    logic [7:0]  msg_type;
    logic [31:0] stream_id;
    logic [31:0] timestamp;
    logic [7:0]  payload;
    logic        last;
  } result_t;

  // Message header length for each format.
  function automatic logic [3:0] hdr_bytes(input logic [1:0] fmt);
    logic [3:0] n;
    case (fmt)
      2'd0:    n = 4'd11;
      2'd1:    n = 4'd7;
      2'd2:    n = 4'd3;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

FILE: rtl/rtmp_chunk_stream_deframer.sv
// Top level of the chunk stream deframer: parser, channel table memory, output register.
//
// Usage: received chunk stream bytes enter on the s_axis channel, one byte per item in
// s_axis_tdata_i. Results leave on m_axis: tuser carries the kind (payload byte,
// zero-length message done, bad channel), tdata the channel, type, stream id,
// timestamp and payload byte, tlast the last byte of a message.
// The per-channel header record lives in a 64-entry memory with a registered read.
// A record is read when a basic header resolves its channel and written back when
// the chunk ends, so every chunk has a bubble, the load state, for the memory read; all
// header and payload bytes otherwise go at one item per cycle when not stalled.
// A result is registered from the byte that causes it, except the zero-length
// result of a format 3 header without extended timestamp, which is formed in the
// load state that follows its basic header.
// Reset clears the parser, the chunk size register (to 128) and the valid bits of
// the channel table; an entry not yet written reads as all zero.
// When the receiver stalls the result is held in the output register and input is
// taken only while that register can be refilled in the same cycle.
// A bad channel id gives one error result; all later bytes are dropped until reset.
// The user writes chunk_size via cfg_we_i / cfg_wdata_i only while idle; not enforced.
`timescale 1ns / 1ps
`include "rtmp_chunk_stream_deframer_defines.svh"
module rtmp_chunk_stream_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [87:0] m_axis_tdata_o,   // [5:0] channel, [13:6] msg_type,
                                        // [45:14] stream_id, [77:46] timestamp,
                                        // [85:78] payload, [87:86] zero
  output logic [1:0]  m_axis_tuser_o,   // [1:0] kind
  output logic        m_axis_tlast_o    // last_of_message
);

  localparam int unsigned CW = rcsd_pkg::ChanW;

  logic [23:0] chunk_size_q;
  logic [3:0]  phase_q, phase_d;
  logic [3:0]  hcount_q, hcount_d;
  logic [31:0] hshift_q, hshift_d;
  logic [CW-1:0] chan_q, chan_d;
  logic [23:0] chunk_left_q, chunk_left_d;
  logic        error_q, error_d;
  logic [1:0]  fmt_q, fmt_d;
  logic [23:0] pend_field_q, pend_field_d;
  logic [7:0]  id_low_q, id_low_d;
  rcsd_pkg::chan_rec_t rec_q, rec_d;

  logic [rcsd_pkg::NumChannels-1:0] valid_q;
  rcsd_pkg::chan_rec_t mem [rcsd_pkg::NumChannels];
  rcsd_pkg::chan_rec_t rd_q;
  logic        rd_en;
  logic [CW-1:0] rd_addr;
  logic        wr_en;

  logic        out_v_q, out_v_d;
  rcsd_pkg::result_t out_q, out_d;
  logic        adv, fire;

  assign adv = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = adv && (phase_q != rcsd_pkg::PhLoad);
  assign fire = s_axis_tvalid_i && s_axis_tready_o;

  // Parse one byte, or finish the record load.
  always_comb begin
    logic [7:0]  b;
    logic [16:0] id;
    logic        resolve;
    logic        finish;
    logic [31:0] pend_ts;
    logic [23:0] cs;
    logic [3:0]  k;
    logic [23:0] cl;
    logic        ext;

    b = s_axis_tdata_i;
    id = '0;
    resolve = 1'b0;
    finish = 1'b0;
    pend_ts = '0;
    k = hcount_q;
    cs = (chunk_size_q == 24'd0) ? 24'd1 : chunk_size_q;
    ext = 1'b0;
    cl = 24'd0;

    phase_d = phase_q;
    hcount_d = hcount_q;
    hshift_d = hshift_q;
    chan_d = chan_q;
    chunk_left_d = chunk_left_q;
    error_d = error_q;
    fmt_d = fmt_q;
    pend_field_d = pend_field_q;
    id_low_d = id_low_q;
    rec_d = rec_q;
    rd_en = 1'b0;
    rd_addr = '0;
    wr_en = 1'b0;
    out_v_d = adv ? 1'b0 : out_v_q;
    out_d = out_q;

    if (phase_q == rcsd_pkg::PhLoad) begin
      if (adv) begin
        rec_d = valid_q[chan_q] ? rd_q : '0;
        if (rcsd_pkg::hdr_bytes(fmt_q) != 4'd0) begin
          phase_d = rcsd_pkg::PhMsgHdr;
        end else if (rec_d.ext) begin
          phase_d = rcsd_pkg::PhExt;
        end else begin
          finish = 1'b1;
          pend_ts = '0;
        end
      end
    end else if (fire) begin
      case (phase_q)
        rcsd_pkg::PhBasic: begin
          fmt_d = b[7:6];
          if (b[5:0] == 6'd0) begin
            phase_d = rcsd_pkg::PhId1;
          end else if (b[5:0] == 6'd1) begin
            phase_d = rcsd_pkg::PhId2a;
          end else begin
            id = {11'd0, b[5:0]};
            resolve = 1'b1;
          end
        end
        rcsd_pkg::PhId1: begin
          id = {9'd0, b} + 17'd64;
          resolve = 1'b1;
        end
        rcsd_pkg::PhId2a: begin
          id_low_d = b;
          phase_d = rcsd_pkg::PhId2b;
        end
        rcsd_pkg::PhId2b: begin
          id = {1'b0, b, id_low_q} + 17'd64;
          resolve = 1'b1;
        end
        rcsd_pkg::PhMsgHdr: begin
          if (k < 4'd3) begin
            hshift_d = {hshift_q[23:0], b};
            if (k == 4'd2) begin
              pend_field_d = hshift_d[23:0];
              hshift_d = '0;
            end
          end else if (k < 4'd6) begin
            hshift_d = {hshift_q[23:0], b};
            if (k == 4'd5) begin
              rec_d.len = hshift_d[23:0];
              hshift_d = '0;
            end
          end else if (k == 4'd6) begin
            rec_d.typ = b;
          end else begin
            hshift_d = {b, hshift_q[31:8]};
            if (k == 4'd10) rec_d.stream = hshift_d;
          end
          hcount_d = k + 4'd1;
          if (hcount_d >= rcsd_pkg::hdr_bytes(fmt_q)) begin
            if (pend_field_d == rcsd_pkg::ExtMarker) begin
              hcount_d = '0;
              hshift_d = '0;
              phase_d = rcsd_pkg::PhExt;
            end else begin
              finish = 1'b1;
              pend_ts = {8'd0, pend_field_d};
            end
          end
        end
        rcsd_pkg::PhExt: begin
          hshift_d = {hshift_q[23:0], b};
          hcount_d = hcount_q + 4'd1;
          if (hcount_d == 4'd4) begin
            finish = 1'b1;
            pend_ts = hshift_d;
          end
        end
        rcsd_pkg::PhPayload: begin
          rec_d.rem = rec_q.rem - 24'd1;
          chunk_left_d = chunk_left_q - 24'd1;
          out_v_d = 1'b1;
          out_d.kind = rcsd_pkg::KindPayload;
          out_d.channel = 6'(chan_q);
          out_d.msg_type = rec_q.typ;
          out_d.stream_id = rec_q.stream;
          out_d.timestamp = rec_q.ts;
          out_d.payload = b;
          out_d.last = 1'b0;
          if (rec_d.rem == 24'd0) begin
            rec_d.inprog = 1'b0;
            out_d.last = 1'b1;
            phase_d = rcsd_pkg::PhBasic;
            wr_en = 1'b1;
          end else if (chunk_left_d == 24'd0) begin
            phase_d = rcsd_pkg::PhBasic;
            wr_en = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // Resolve the channel id: flag an error or fetch the record.
    if (resolve) begin
      if (id >= 17'(rcsd_pkg::NumChannels)) begin
        error_d = 1'b1;
        phase_d = rcsd_pkg::PhError;
        out_v_d = 1'b1;
        out_d = '0;
        out_d.kind = rcsd_pkg::KindBadChan;
      end else begin
        chan_d = id[CW-1:0];
        hcount_d = '0;
        hshift_d = '0;
        pend_field_d = '0;
        rd_en = 1'b1;
        rd_addr = id[CW-1:0];
        phase_d = rcsd_pkg::PhLoad;
      end
    end

    // Apply the completed header to the working record.
    if (finish) begin
      if (fmt_q < 2'd3) begin
        ext = (pend_field_d == rcsd_pkg::ExtMarker);
        rec_d.ext = ext;
      end else begin
        ext = rec_d.ext;
      end
      if (fmt_q < 2'd3 || ext) rec_d.delta = pend_ts;
      phase_d = rcsd_pkg::PhPayload;
      if (!rec_d.inprog) begin
        rec_d.ts = (fmt_q == 2'd0) ? pend_ts : rec_d.ts + rec_d.delta;
        rec_d.rem = rec_d.len;
        if (rec_d.len == 24'd0) begin
          phase_d = rcsd_pkg::PhBasic;
          wr_en = 1'b1;
          out_v_d = 1'b1;
          out_d.kind = rcsd_pkg::KindEmpty;
          out_d.channel = 6'(chan_q);
          out_d.msg_type = rec_d.typ;
          out_d.stream_id = rec_d.stream;
          out_d.timestamp = rec_d.ts;
          out_d.payload = '0;
          out_d.last = 1'b1;
        end else begin
          rec_d.inprog = 1'b1;
        end
      end
      cl = (rec_d.rem < cs) ? rec_d.rem : cs;
      chunk_left_d = cl;
    end
  end

  // Channel table memory: write back at chunk end, registered read at resolve.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[chan_q] <= rec_d;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  // Valid bits of the table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[chan_q] <= 1'b1;
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_size_q <= rcsd_pkg::ChunkSizeReset;
      phase_q <= rcsd_pkg::PhBasic;
      hcount_q <= '0;
      hshift_q <= '0;
      chan_q <= '0;
      chunk_left_q <= '0;
      error_q <= 1'b0;
      fmt_q <= '0;
      pend_field_q <= '0;
      id_low_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) chunk_size_q <= cfg_wdata_i;
      phase_q <= phase_d;
      hcount_q <= hcount_d;
      hshift_q <= hshift_d;
      chan_q <= chan_d;
      chunk_left_q <= chunk_left_d;
      error_q <= error_d;
      fmt_q <= fmt_d;
      pend_field_q <= pend_field_d;
      id_low_q <= id_low_d;
      out_v_q <= out_v_d;
    end
  end

  // Payload registers: working record and result.
  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
    out_q <= out_d;
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tuser_o = out_q.kind;
  assign m_axis_tlast_o = out_q.last;
  assign m_axis_tdata_o = {2'b00, out_q.payload, out_q.timestamp, out_q.stream_id,
                           out_q.msg_type, out_q.channel};

  `RCSD_ASSERT(a_err_sticky, (phase_q != rcsd_pkg::PhError) || error_q, "error phase without flag")
  `RCSD_ASSERT(a_chunk_left, (phase_q != rcsd_pkg::PhPayload) || (chunk_left_q != 24'd0), "empty chunk in payload")
  `RCSD_ASSERT_NEXT(a_load_once, phase_q == rcsd_pkg::PhLoad && adv, phase_q != rcsd_pkg::PhLoad, "load stuck")
  `RCSD_ASSERT(a_no_ready_load, !(s_axis_tready_o && phase_q == rcsd_pkg::PhLoad), "input taken during load")

endmodule
